/* src/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion converter
// Holds the component codes, default widths and width helper functions.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Quaternion component codes, in output order.
  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z,
    COMP_W
  } comp_t;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int FIFO_DEPTH     = 4;

  // Radicand width: the largest diagonal radicand stays below 2^(dw+2).
  function automatic int rad_w(input int dw);
    return dw + 2;
  endfunction

  // Root width: half of the radicand width after scaling, rounded up.
  function automatic int root_w(input int dw, input int fb);
    return (rad_w(dw) + fb + 1) >> 1;
  endfunction

  // Queue entry: branch flag, main component, four numerators, radicand.
  function automatic int entry_w(input int dw);
    return 1 + 2 + 4 * (dw + 1) + rad_w(dw);
  endfunction

endpackage

/* src/rmq_ifs.sv */
// ----------------------------------------------------------------------------
// rmq_ifs: channel interfaces of the matrix to quaternion converter
// Matrix input channel and quaternion result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rmq_mat_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] m_r0c0;
  logic signed [DW-1:0] m_r0c1;
  logic signed [DW-1:0] m_r0c2;
  logic signed [DW-1:0] m_r1c0;
  logic signed [DW-1:0] m_r1c1;
  logic signed [DW-1:0] m_r1c2;
  logic signed [DW-1:0] m_r2c0;
  logic signed [DW-1:0] m_r2c1;
  logic signed [DW-1:0] m_r2c2;

  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, input ready);
  modport sink   (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface rmq_quat_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] quat_x;
  logic signed [DW-1:0] quat_y;
  logic signed [DW-1:0] quat_z;
  logic signed [DW-1:0] quat_w;
  logic                 zero_root;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, zero_root, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, zero_root, output ready);
endinterface

/* src/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: fixed-point rotation matrix to quaternion
// Shepperd's method on a 3x3 matrix, saturated signed results.
// ----------------------------------------------------------------------------
// The block takes one 3x3 rotation matrix per transaction and returns one
// quaternion per transaction, in order. It accepts a new matrix every clock
// cycle and keeps doing so while earlier matrices are still in flight, so the
// sustained rate is one transaction per cycle; back-pressure on the result
// channel stalls the arithmetic pipeline and, once the small queue fills, the
// input side. The pipeline depth is set by the square root, which produces one
// root bit per stage, and by the four dividers, which produce one quotient bit
// per stage; the default format is Q1.14 in 16 bits. A 4x4 matrix is handled
// by feeding its upper 3x3 part. When the diagonal branch finds a zero root,
// all four components are zero and zero_root is raised.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rmq_mat_if.sink     in_ch,
  rmq_quat_if.source  out_ch
);

  localparam int EW = entry_w(DATA_WIDTH);

  // Classified transaction on its way from the front stage to the queue.
  logic          f_valid, f_ready;
  logic [EW-1:0] f_data;
  // Queue head on its way to the arithmetic pipeline.
  logic          q_valid, q_ready;
  logic [EW-1:0] q_data;

  // Front part: branch selection, radicand and numerators.
  rmq_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  // Queue that lets the front keep taking transactions during short stalls.
  rmq_fifo #(.W(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Back part: root, division, rounding and saturation.
  rmq_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data),
    .out_ch    (out_ch)
  );

endmodule

/* src/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front: classification stage
// Picks the branch and main component, forms the radicand and numerators.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rmq_mat_if.sink                in_ch,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [entry_w(DW)-1:0] push_data
);

  localparam int RW = rad_w(DW);
  localparam logic signed [DW+2:0] ONE = (DW+3)'(1) <<< FB;

  typedef struct packed {
    logic                trc;
    comp_t               mi;
    logic [3:0][DW:0]    num;
    logic [RW-1:0]       rad;
  } entry_t;

  logic signed [DW-1:0] m [3][3];
  logic signed [DW+1:0] tr;
  logic signed [DW+2:0] rad_s;
  logic signed [DW-1:0] mii, mjj, mkk;
  comp_t                isel;
  entry_t               ent_nxt, ent_r;
  logic                 vld_r;

  assign m[0][0] = in_ch.m_r0c0;
  assign m[0][1] = in_ch.m_r0c1;
  assign m[0][2] = in_ch.m_r0c2;
  assign m[1][0] = in_ch.m_r1c0;
  assign m[1][1] = in_ch.m_r1c1;
  assign m[1][2] = in_ch.m_r1c2;
  assign m[2][0] = in_ch.m_r2c0;
  assign m[2][1] = in_ch.m_r2c1;
  assign m[2][2] = in_ch.m_r2c2;

  function automatic logic [DW:0] dif(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b);
    logic signed [DW:0] r;
    r = (DW+1)'(a) - (DW+1)'(b);
    return r;
  endfunction

  function automatic logic [DW:0] add(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b);
    logic signed [DW:0] r;
    r = (DW+1)'(a) + (DW+1)'(b);
    return r;
  endfunction

  always_comb begin
    tr = (DW+2)'(m[0][0]) + (DW+2)'(m[1][1]) + (DW+2)'(m[2][2]);
    // Ties keep the lower diagonal index.
    isel = COMP_X;
    if (m[1][1] > m[0][0]) isel = COMP_Y;
    mii = (isel == COMP_Y) ? m[1][1] : m[0][0];
    if (m[2][2] > mii) isel = COMP_Z;
    case (isel)
      COMP_Y: begin
        mii = m[1][1]; mjj = m[2][2]; mkk = m[0][0];
      end
      COMP_Z: begin
        mii = m[2][2]; mjj = m[0][0]; mkk = m[1][1];
      end
      default: begin
        mii = m[0][0]; mjj = m[1][1]; mkk = m[2][2];
      end
    endcase

    ent_nxt = '0;
    ent_nxt.trc = (tr > 0);
    if (ent_nxt.trc) begin
      rad_s = (DW+3)'(tr) + ONE;
      ent_nxt.mi = COMP_W;
      ent_nxt.num[COMP_X] = dif(m[1][2], m[2][1]);
      ent_nxt.num[COMP_Y] = dif(m[2][0], m[0][2]);
      ent_nxt.num[COMP_Z] = dif(m[0][1], m[1][0]);
    end else begin
      rad_s = (DW+3)'(mii) - ((DW+3)'(mjj) + (DW+3)'(mkk)) + ONE;
      ent_nxt.mi = isel;
      case (isel)
        COMP_Y: begin
          ent_nxt.num[COMP_W] = dif(m[2][0], m[0][2]);
          ent_nxt.num[COMP_Z] = add(m[1][2], m[2][1]);
          ent_nxt.num[COMP_X] = add(m[1][0], m[0][1]);
        end
        COMP_Z: begin
          ent_nxt.num[COMP_W] = dif(m[0][1], m[1][0]);
          ent_nxt.num[COMP_X] = add(m[2][0], m[0][2]);
          ent_nxt.num[COMP_Y] = add(m[2][1], m[1][2]);
        end
        default: begin
          ent_nxt.num[COMP_W] = dif(m[1][2], m[2][1]);
          ent_nxt.num[COMP_Y] = add(m[0][1], m[1][0]);
          ent_nxt.num[COMP_Z] = add(m[0][2], m[2][0]);
        end
      endcase
    end
    // A negative radicand is clamped to zero.
    ent_nxt.rad = rad_s[DW+2] ? '0 : rad_s[RW-1:0];
  end

  assign in_ch.ready = !vld_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      ent_r <= ent_nxt;
    end
  end

  assign push_valid = vld_r;
  assign push_data  = ent_r;

endmodule

/* src/rmq_fifo.sv */
// ----------------------------------------------------------------------------
// rmq_fifo: small queue between the classification and arithmetic parts
// Register based first-in first-out buffer with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rmq_fifo import rmq_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

/* src/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back: arithmetic pipeline
// Bit-per-stage square root, bit-per-stage dividers, rounding and saturation.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [entry_w(DW)-1:0] pop_data,
  rmq_quat_if.source             out_ch
);

  localparam int RW  = rad_w(DW);
  localparam int RTW = root_w(DW, FB);
  localparam int SW  = 2 * RTW;
  localparam int RMW = RTW + 3;
  localparam int CA  = DW + FB + 2;
  localparam int CB  = RTW + DW + 1;
  localparam int CW  = ((CA > CB) ? CA : CB) + 1;
  localparam int MXW = ((RTW > DW) ? RTW : DW);
  localparam logic [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                trc;
    comp_t               mi;
    logic [3:0][DW:0]    num;
    logic [RW-1:0]       rad;
  } entry_t;

  typedef struct packed {
    logic [RMW-1:0]   rem;
    logic [RTW-1:0]   root;
    logic [SW-1:0]    v;
    logic [3:0][DW:0] num;
    comp_t            mi;
    logic             trc;
  } sq_t;

  typedef struct packed {
    logic [3:0][CW-1:0] r;
    logic [3:0][DW-1:0] q;
    logic [3:0]         ovf;
    logic [3:0]         neg;
    logic [RTW-1:0]     root;
    comp_t              mi;
    logic               trc;
  } dv_t;

  entry_t     ent;
  logic       adv;
  sq_t        sq_r  [RTW+1];
  logic       sqv_r [RTW+1];
  dv_t        dv_r  [DW+1];
  logic       dvv_r [DW+1];
  sq_t        sq_nxt [RTW];
  dv_t        dv_nxt [DW+1];
  logic [DW-1:0] res_nxt [4];
  logic       zr_nxt;
  logic [DW-1:0] res_r [4];
  logic       zr_r;
  logic       ov_r;

  assign ent       = pop_data;
  assign adv       = !ov_r || out_ch.ready;
  assign pop_ready = adv;

  // Square root: one result bit per stage.
  for (genvar k = 0; k < RTW; k++) begin : g_sq
    always_comb begin
      logic [RMW-1:0] rem2;
      logic [RMW-1:0] trial;
      sq_nxt[k] = sq_r[k];
      rem2  = {sq_r[k].rem[RMW-3:0], sq_r[k].v[SW-1:SW-2]};
      trial = RMW'({sq_r[k].root, 2'b01});
      if (rem2 >= trial) begin
        sq_nxt[k].rem  = rem2 - trial;
        sq_nxt[k].root = {sq_r[k].root[RTW-2:0], 1'b1};
      end else begin
        sq_nxt[k].rem  = rem2;
        sq_nxt[k].root = {sq_r[k].root[RTW-2:0], 1'b0};
      end
      sq_nxt[k].v = {sq_r[k].v[SW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sqv_r[k+1] <= sqv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) sq_r[k+1] <= sq_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r[0] <= 1'b0;
    end else if (adv) begin
      sqv_r[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].v    <= SW'(ent.rad) << FB;
      sq_r[0].num  <= ent.num;
      sq_r[0].mi   <= ent.mi;
      sq_r[0].trc  <= ent.trc;
    end
  end

  // Divider set-up: magnitudes, rounding offset and overflow check.
  always_comb begin
    logic [DW:0]   mag;
    logic [CW-1:0] dext;
    logic [CW-1:0] nval;
    dv_nxt[0]      = '0;
    dv_nxt[0].root = sq_r[RTW].root;
    dv_nxt[0].mi   = sq_r[RTW].mi;
    dv_nxt[0].trc  = sq_r[RTW].trc;
    dext = CW'({sq_r[RTW].root, 1'b0});
    for (int a = 0; a < 4; a++) begin
      dv_nxt[0].neg[a] = sq_r[RTW].num[a][DW];
      mag  = sq_r[RTW].num[a][DW] ? (DW+1)'(-sq_r[RTW].num[a]) : sq_r[RTW].num[a];
      nval = (CW'(mag) << FB) + CW'(sq_r[RTW].root);
      dv_nxt[0].r[a]   = nval;
      dv_nxt[0].ovf[a] = (nval >= (dext << DW));
    end
  end

  // Restoring division: one quotient bit per stage, four lanes.
  for (genvar t = 0; t < DW; t++) begin : g_dv
    always_comb begin
      logic [CW-1:0] sub;
      dv_nxt[t+1] = dv_r[t];
      sub = CW'({dv_r[t].root, 1'b0}) << (DW - 1 - t);
      for (int a = 0; a < 4; a++) begin
        if (dv_r[t].r[a] >= sub) begin
          dv_nxt[t+1].r[a]          = dv_r[t].r[a] - sub;
          dv_nxt[t+1].q[a][DW-1-t]  = 1'b1;
        end
      end
    end
  end

  for (genvar t = 0; t <= DW; t++) begin : g_dvr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[t] <= 1'b0;
      end else if (adv) begin
        dvv_r[t] <= (t == 0) ? sqv_r[RTW] : dvv_r[(t == 0) ? 0 : t - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) dv_r[t] <= dv_nxt[(t == 0) ? 0 : t];
    end
  end

  // Output: main component, saturation and the zero-root case.
  always_comb begin
    logic [RTW-1:0] half;
    logic [DW-1:0]  qv;
    half   = dv_r[DW].root >> 1;
    zr_nxt = !dv_r[DW].trc && (dv_r[DW].root == '0);
    for (int a = 0; a < 4; a++) begin
      qv = dv_r[DW].q[a];
      if (comp_t'(a) == dv_r[DW].mi) begin
        res_nxt[a] = (MXW'(half) > MXW'(HI)) ? HI : DW'(half);
      end else if (zr_nxt) begin
        res_nxt[a] = '0;
      end else if (!dv_r[DW].neg[a]) begin
        res_nxt[a] = (dv_r[DW].ovf[a] || qv[DW-1]) ? HI : qv;
      end else begin
        res_nxt[a] = (dv_r[DW].ovf[a] || (qv[DW-1] && (qv[DW-2:0] != '0))) ? LO : -qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dvv_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      zr_r  <= zr_nxt;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.quat_x    = res_r[COMP_X];
  assign out_ch.quat_y    = res_r[COMP_Y];
  assign out_ch.quat_z    = res_r[COMP_Z];
  assign out_ch.quat_w    = res_r[COMP_W];
  assign out_ch.zero_root = zr_r;

endmodule

/* src/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker: port-level assertions for the converter
// Watches the result handshake, the reset state and the zero-root result over time.
// ----------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] quat_x,
  input logic signed [DW-1:0] quat_y,
  input logic signed [DW-1:0] quat_z,
  input logic signed [DW-1:0] quat_w,
  input logic                 zero_root
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(quat_x) && $stable(quat_y) &&
      $stable(quat_z) && $stable(quat_w) && $stable(zero_root))
    else $error("result changed while stalled");

  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_root |-> quat_x == '0 && quat_y == '0 &&
      quat_z == '0 && quat_w == '0)
    else $error("zero root with a nonzero component");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not empty and ready after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DW(DATA_WIDTH)) u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .quat_x    (out_ch.quat_x),
  .quat_y    (out_ch.quat_y),
  .quat_z    (out_ch.quat_z),
  .quat_w    (out_ch.quat_w),
  .zero_root (out_ch.zero_root)
);

/* verif/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_scoreboard: quaternion predictor and result checker
// Watches both channels, computes the expected quaternion of every accepted
// matrix and compares each accepted result against the oldest expectation.
// ----------------------------------------------------------------------------
module rmq_scoreboard #(
  parameter int DW = 16,
  parameter int FB = 14
) (
  input  logic clk,
  input  logic rst_n,
  rmq_mat_if   mat,
  rmq_quat_if  quat,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] w;
    logic                 zr;
  } quat_t;

  quat_t quat_expected[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_pos;
    res = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (v >= res + bit_pos) begin
        v -= res + bit_pos;
        res = (res >> 1) + bit_pos;
      end else begin
        res >>= 1;
      end
      bit_pos >>= 2;
    end
    return res;
  endfunction

  // n * 2^FB / (2 * root), rounded half away from zero.
  function automatic longint half_over_root(longint n, longint unsigned root);
    longint unsigned mag, d, q;
    mag = (n < 0) ? -n : n;
    d = root << 1;
    q = ((mag << FB) + (d >> 1)) / d;
    if (q > (64'd1 << 62)) q = 64'd1 << 62;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [DW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DW-1:0];
  endfunction

  function automatic quat_t predict_quat(longint m[3][3]);
    longint q[4], one, tr, rad;
    longint unsigned root;
    int i, j, k;
    quat_t r;
    one = longint'(1) << FB;
    r.zr = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = int_sqrt(longint'(tr + one) << FB);
      q[3] = root >> 1;
      q[0] = half_over_root(m[1][2] - m[2][1], root);
      q[1] = half_over_root(m[2][0] - m[0][2], root);
      q[2] = half_over_root(m[0][1] - m[1][0], root);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i == 2) ? 0 : i + 1;
      k = (j == 2) ? 0 : j + 1;
      rad = m[i][i] - (m[j][j] + m[k][k]) + one;
      if (rad < 0) rad = 0;
      root = int_sqrt(rad << FB);
      q[i] = root >> 1;
      if (root == 0) begin
        r.zr = 1'b1;
        q[3] = 0;
        q[j] = 0;
        q[k] = 0;
      end else begin
        q[3] = half_over_root(m[j][k] - m[k][j], root);
        q[j] = half_over_root(m[i][j] + m[j][i], root);
        q[k] = half_over_root(m[i][k] + m[k][i], root);
      end
    end
    r.x = clamp(q[0]);
    r.y = clamp(q[1]);
    r.z = clamp(q[2]);
    r.w = clamp(q[3]);
    return r;
  endfunction

  always @(posedge clk) begin
    longint m[3][3];
    quat_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (mat.valid && mat.ready) begin
        m[0][0] = mat.m_r0c0; m[0][1] = mat.m_r0c1; m[0][2] = mat.m_r0c2;
        m[1][0] = mat.m_r1c0; m[1][1] = mat.m_r1c1; m[1][2] = mat.m_r1c2;
        m[2][0] = mat.m_r2c0; m[2][1] = mat.m_r2c1; m[2][2] = mat.m_r2c2;
        quat_expected.push_back(predict_quat(m));
      end
      if (quat.valid && quat.ready) begin
        if (quat_expected.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d zr=%0b", $time,
                   quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w, quat.zero_root);
          fail_count <= fail_count + 1;
        end else begin
          e = quat_expected.pop_front();
          if (e.x !== quat.quat_x || e.y !== quat.quat_y || e.z !== quat.quat_z ||
              e.w !== quat.quat_w || e.zr !== quat.zero_root) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d zr=%0b", $time,
                     e.x, e.y, e.z, e.w, e.zr);
            $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d zr=%0b", $time,
                     quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w, quat.zero_root);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= quat_expected.size();
  end
endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench top for the matrix to quaternion converter
// Drives directed and random matrices with random gaps and result stalls,
// including a long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  // Pipeline depth from the accepting edge to the shown result.
  localparam int LATENCY = 4 + ((DW + 2 + FB + 1) >> 1) + DW;
  localparam int N_RANDOM = 1130;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  longint cycles = 0;
  // Set while the receiver is forced into a long hold-off.
  bit   hold_off = 1'b0;
  // Cycles the receiver still waits before taking the next result.
  int   rx_wait = 0;

  rmq_mat_if  #(.DW(DW)) mat_ch ();
  rmq_quat_if #(.DW(DW)) quat_ch ();

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(mat_ch.sink), .out_ch(quat_ch.source)
  );

  rmq_scoreboard #(.DW(DW), .FB(FB)) checker_i (
    .clk(clk), .rst_n(rst_n), .mat(mat_ch), .quat(quat_ch),
    .fail_count(fail_count), .pending(pending)
  );

  typedef logic signed [DW-1:0] elem_t;
  localparam elem_t ONE  = elem_t'(1 << FB);
  localparam elem_t HALF = elem_t'(1 << (FB - 1));
  localparam elem_t MAXV = elem_t'((1 << (DW - 1)) - 1);
  localparam elem_t MINV = elem_t'(-(1 << (DW - 1)));

  initial begin
    mat_ch.valid = 1'b0;
    {mat_ch.m_r0c0, mat_ch.m_r0c1, mat_ch.m_r0c2} = '0;
    {mat_ch.m_r1c0, mat_ch.m_r1c1, mat_ch.m_r1c2} = '0;
    {mat_ch.m_r2c0, mat_ch.m_r2c1, mat_ch.m_r2c2} = '0;
    quat_ch.ready = 1'b0;
  end

  // Offers one matrix and holds it until the transaction completes. The gap
  // before it is drawn per item.
  task automatic send_matrix(input elem_t e[9], input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      mat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat_ch.valid  <= 1'b1;
    mat_ch.m_r0c0 <= e[0]; mat_ch.m_r0c1 <= e[1]; mat_ch.m_r0c2 <= e[2];
    mat_ch.m_r1c0 <= e[3]; mat_ch.m_r1c1 <= e[4]; mat_ch.m_r1c2 <= e[5];
    mat_ch.m_r2c0 <= e[6]; mat_ch.m_r2c1 <= e[7]; mat_ch.m_r2c2 <= e[8];
    do @(posedge clk); while (!mat_ch.ready);
  endtask

  task automatic send_diag(input elem_t a, input elem_t b, input elem_t c);
    elem_t e[9];
    foreach (e[n]) e[n] = elem_t'($urandom_range(0, 4000) - 2000);
    e[0] = a; e[4] = b; e[8] = c;
    send_matrix(e);
  endtask

  // Random rotation-like matrix: every element mostly within [-1, 1], with the
  // occasional fully random matrix to reach saturation.
  task automatic send_random();
    elem_t e[9];
    int mode;
    mode = $urandom_range(0, 9);
    foreach (e[n]) begin
      if (mode == 0) e[n] = elem_t'($urandom);
      else if (n == 0 || n == 4 || n == 8)
        e[n] = elem_t'($urandom_range(0, 2 * 16384)) - ONE;
      else e[n] = elem_t'($urandom_range(0, 2 * 16384)) - ONE;
    end
    if (mode == 1) begin
      // Push toward a negative trace so the diagonal branches get exercised.
      e[$urandom_range(0, 2) * 4] = elem_t'($urandom_range(0, 16384));
      e[0] = e[0] - ONE; e[4] = e[4] - HALF;
    end
    send_matrix(e);
  endtask

  // Receiver: draws its wait at random per result, or holds off while a long
  // hold-off is requested.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      quat_ch.ready <= 1'b0;
    end else if (quat_ch.valid && quat_ch.ready) begin
      rx_wait = $urandom_range(0, 3);
      quat_ch.ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      quat_ch.ready <= (rx_wait == 0);
    end else begin
      quat_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    elem_t e[9];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, extremes, trace boundary and all diagonal branches.
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; send_matrix(e);
    e = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send_matrix(e);
    e = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; send_matrix(e);
    e = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV}; send_matrix(e);
    e = '{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV}; send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    e = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    e = '{ONE, 5, 7, 9, -ONE, 3, 4, 6, -ONE}; send_matrix(e);
    e = '{-ONE, 5, 7, 9, ONE, 3, 4, 6, -ONE}; send_matrix(e);
    e = '{-ONE, 5, 7, 9, -ONE, 3, 4, 6, ONE}; send_matrix(e);
    e = '{-ONE, 100, 200, 300, -ONE, 400, 500, 600, -ONE}; send_matrix(e);
    e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(e);
    // Ties between diagonal elements keep the lower index.
    e = '{0, 11, 22, 33, 0, 44, 55, 66, 0}; send_matrix(e);
    e = '{-ONE, 11, 22, 33, 0, 44, 55, 66, 0}; send_matrix(e);
    // Extreme and mixed diagonal values with random or extreme off-diagonal elements.
    send_diag(MINV, MINV, MINV);
    send_diag(-ONE, -HALF, -HALF);
    send_diag(MINV, 0, MAXV);
    send_diag(MAXV, MINV, MINV);
    send_diag(MINV, MAXV, MINV);
    e = '{1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, 0}; send_matrix(e);
    e = '{MINV, MAXV, MAXV, MINV, MINV, MAXV, MINV, MINV, MAXV}; send_matrix(e);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) begin
        // Hold the receiver off while the sender keeps offering items.
        hold_off = 1'b1;
        fork
          begin
            repeat (LATENCY + 60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 600) begin
        // Pause the sender until every expected result has arrived.
        mat_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random();
    end
    mat_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
